// ===== hdl/ksdp_pkg.sv =====
// shared widths and constants for the knapsack best-value engine
`default_nettype none

package ksdp_pkg;

  localparam int unsigned MAX_CAPACITY_DEF = 1023;

  localparam int unsigned CAP_W    = 10;
  localparam int unsigned WEIGHT_W = 10;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned BEST_W   = 24;

  localparam logic [BEST_W-1:0] BEST_MAX = {BEST_W{1'b1}};

endpackage

`default_nettype wire

// ===== hdl/ksdp_ram.sv =====
// generic single write, dual read memory with registered read data
`default_nettype none

module ksdp_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== hdl/knapsack_dp_max_value_top.sv =====
// 0/1 knapsack best-value engine: one-row table walked by a shared update unit
//
// Usage:
//   cfg_we_i/cfg_wdata_i write the capacity register; write it only while idle.
//   The input channel (in_valid_i, in_stall_o) takes one item per transaction:
//   weight, value and a last-item flag. The output channel (out_valid_o,
//   out_stall_i) returns the best value once per set, on its last item.
// Timing:
//   The table lives in a memory; the update unit reads entry c and entry
//   c - weight, adds and compares, and writes entry c back, one entry per cycle
//   walking down from cap to 1 (cap = min(capacity, MAX_CAPACITY)); the walk is
//   skipped when cap is zero in an open set. The first item of a set walks the
//   whole table down from MAX_CAPACITY, clearing the entries above cap as it
//   goes. in_stall_o is high while an item is in progress.
// Reset:
//   Clears the capacity register, the sequencer, the set-open flag and the
//   output valid flag; the memory is not cleared, the first item of each set overwrites it instead.
// Stalls:
//   A finished result waits in the output register while the next item is
//   already taken; only a further result waits for that one to be taken.
`default_nettype none

module knapsack_dp_max_value_top #(
  parameter int unsigned MAX_CAPACITY = ksdp_pkg::MAX_CAPACITY_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [ksdp_pkg::CAP_W-1:0]         cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [ksdp_pkg::WEIGHT_W-1:0]      item_weight_i,
  input  wire logic [ksdp_pkg::VALUE_W-1:0]       item_value_i,
  input  wire logic                               last_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [ksdp_pkg::BEST_W-1:0]        best_value_o
);

  localparam int unsigned DEPTH = MAX_CAPACITY + 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMPW  = (AW > ksdp_pkg::CAP_W) ? AW : ksdp_pkg::CAP_W;
  localparam int unsigned BW    = ksdp_pkg::BEST_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [ksdp_pkg::CAP_W-1:0] cap_reg_q;
  logic                       set_open_q, set_open_d;
  logic                       out_valid_q, out_valid_d;
  logic [BW-1:0]              out_data_q, out_data_d;

  // item context
  logic [ksdp_pkg::WEIGHT_W-1:0] w_q, w_d;
  logic [ksdp_pkg::VALUE_W-1:0]  v_q, v_d;
  logic                          last_q, last_d;
  logic                          first_q, first_d;
  logic [AW-1:0]                 cap_eff_q, cap_eff_d;
  logic [AW-1:0]                 c_q, c_d;
  logic [BW-1:0]                 res_q, res_d;

  // update stage, aligned with the memory read data
  logic          s1_valid_q, s1_valid_d;
  logic [AW-1:0] s1_addr_q;
  logic          s1_range_q, s1_fits_q, s1_bzero_q;

  logic [CMPW-1:0] cap_ext, max_ext, c_ext, w_ext;
  logic [AW-1:0]   cap_now, start_c, addr_b;
  logic            fits, bzero, in_range;
  logic            in_accept;

  logic [BW-1:0]   rd_a, rd_b, old_val, base_val, cand, new_val;
  logic [BW:0]     sum;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);

  // effective capacity, saturated at MAX_CAPACITY, the top table entry
  always_comb begin
    cap_ext = CMPW'(cap_reg_q);
    max_ext = CMPW'(MAX_CAPACITY);
    cap_now = (cap_ext > max_ext) ? AW'(max_ext) : AW'(cap_ext);
    start_c = (!set_open_q) ? AW'(MAX_CAPACITY) : cap_now;
  end

  // address side of the walk
  always_comb begin
    c_ext    = CMPW'(c_q);
    w_ext    = CMPW'(w_q);
    fits     = (c_ext >= w_ext);
    bzero    = (c_ext == w_ext);
    in_range = (c_q <= cap_eff_q);
    addr_b   = AW'(c_ext - w_ext);
  end

  ksdp_ram #(
    .WIDTH (BW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (s1_valid_q),
    .waddr_i   (s1_addr_q),
    .wdata_i   (new_val),
    .raddr_a_i (c_q),
    .rdata_a_o (rd_a),
    .raddr_b_i (addr_b),
    .rdata_b_o (rd_b)
  );

  // shared update unit: saturating add and compare
  always_comb begin
    old_val  = first_q ? '0 : rd_a;
    // entry 0 is never written, so a read of it is taken as zero
    base_val = (first_q || s1_bzero_q) ? '0 : rd_b;
    sum      = {1'b0, base_val} + (BW + 1)'(v_q);
    cand     = sum[BW] ? ksdp_pkg::BEST_MAX : sum[BW-1:0];
    if (!s1_range_q) begin
      new_val = '0;
    end else if (s1_fits_q && (cand > old_val)) begin
      new_val = cand;
    end else begin
      new_val = old_val;
    end
  end

  always_comb begin
    state_d     = state_q;
    set_open_d  = set_open_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    w_d         = w_q;
    v_d         = v_q;
    last_d      = last_q;
    first_d     = first_q;
    cap_eff_d   = cap_eff_q;
    c_d         = c_q;
    res_d       = res_q;
    s1_valid_d  = 1'b0;

    if (s1_valid_q && (s1_addr_q == cap_eff_q)) begin
      res_d = new_val;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          w_d       = item_weight_i;
          v_d       = item_value_i;
          last_d    = last_item_i;
          first_d   = !set_open_q;
          cap_eff_d = cap_now;
          c_d       = start_c;
          res_d     = '0;
          state_d   = (start_c == '0) ? ST_FINISH : ST_WALK;
        end
      end
      ST_WALK: begin
        s1_valid_d = 1'b1;
        c_d        = c_q - AW'(1);
        if (c_q == AW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!last_q) begin
          set_open_d = 1'b1;
          state_d    = ST_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          set_open_d  = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_reg_q   <= '0;
      set_open_q  <= 1'b0;
      out_valid_q <= 1'b0;
      s1_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      set_open_q  <= set_open_d;
      out_valid_q <= out_valid_d;
      s1_valid_q  <= s1_valid_d;
      if (cfg_we_i) begin
        cap_reg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    w_q        <= w_d;
    v_q        <= v_d;
    last_q     <= last_d;
    first_q    <= first_d;
    cap_eff_q  <= cap_eff_d;
    c_q        <= c_d;
    res_q      <= res_d;
    s1_addr_q  <= c_q;
    s1_range_q <= in_range;
    s1_fits_q  <= fits;
    s1_bzero_q <= bzero;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign best_value_o = out_data_q;

endmodule

`default_nettype wire

// ===== hdl/ksdp_checker.sv =====
// port-level checks for the knapsack engine, bound to the top level
`default_nettype none

module ksdp_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [ksdp_pkg::BEST_W-1:0]  best_value_o
);

  // the walk keeps the input side busy after every transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again straight after a transaction");

  // a result only appears at the end of an item in progress
  a_result_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in progress");

  a_out_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(best_value_o))
    else $error("result changed while stalled");

endmodule

bind knapsack_dp_max_value_top ksdp_checker u_ksdp_checker (.*);

`default_nettype wire
